// ===== hdl/rpwc_pkg.sv =====
// ----------------------------------------------------------------------------
// rpwc_pkg
// Shared types and constants for the relation path walk block.
// ----------------------------------------------------------------------------
package rpwc_pkg;

  localparam int ACT_W  = 3;
  localparam int ENT_W  = 10;
  localparam int REL_W  = 6;
  localparam int IDX_W  = 10;
  localparam int STAT_W = 2;
  localparam int SIZE_W = 11;
  localparam int CNT_W  = 48;
  localparam int CFG_W  = 11;
  localparam int CFGI_W = 1;
  localparam int ECNT_W = 11;
  localparam int RCNT_W = 7;

  localparam logic [ECNT_W-1:0] ENTITY_COUNT_RESET   = 11'd1024;
  localparam logic [RCNT_W-1:0] RELATION_COUNT_RESET = 7'd64;
  localparam logic [CNT_W-1:0]  COUNT_CAP            = '1;

  localparam logic [CFGI_W-1:0] REG_ENTITY_COUNT   = 1'd0;
  localparam logic [CFGI_W-1:0] REG_RELATION_COUNT = 1'd1;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR = 3'd0,
    ACT_ADD   = 3'd1,
    ACT_START = 3'd2,
    ACT_STEP  = 3'd3,
    ACT_READ  = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ARG   = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_SWEEP, S_IDLE, S_ADD_RD, S_ADD_LINK, S_ADD_TERM, S_START,
    S_READ_RD, S_READ_D, S_STEP_LV, S_STEP_LVD, S_STEP_FD, S_STEP_TD,
    S_STEP_AD, S_CP_RD, S_CP_LD, S_CP_AD, S_DONE
  } state_t;

endpackage

// ===== hdl/rpwc_req_if.sv =====
// ----------------------------------------------------------------------------
// rpwc_req_if
// Request channel: valid/ready with the fields of one command word.
// ----------------------------------------------------------------------------
interface rpwc_req_if;
  logic                        valid;
  logic                        ready;
  logic [rpwc_pkg::ACT_W-1:0]  action;
  logic [rpwc_pkg::ENT_W-1:0]  head_entity;
  logic [rpwc_pkg::REL_W-1:0]  relation_id;
  logic [rpwc_pkg::ENT_W-1:0]  tail_entity;
  logic [rpwc_pkg::IDX_W-1:0]  result_index;

  modport source (output valid, action, head_entity, relation_id, tail_entity,
                  result_index, input ready);
  modport sink (input valid, action, head_entity, relation_id, tail_entity,
                result_index, output ready);
endinterface

// ===== hdl/rpwc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rpwc_rsp_if
// Response channel: valid/ready with the fields of one result word.
// ----------------------------------------------------------------------------
interface rpwc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [rpwc_pkg::STAT_W-1:0] status;
  logic [rpwc_pkg::SIZE_W-1:0] level_size;
  logic [rpwc_pkg::ENT_W-1:0]  result_entity;
  logic [rpwc_pkg::CNT_W-1:0]  path_count;

  modport source (output valid, status, level_size, result_entity, path_count,
                  input ready);
  modport sink (input valid, status, level_size, result_entity, path_count,
                output ready);
endinterface

// ===== hdl/rpwc_ram.sv =====
// ----------------------------------------------------------------------------
// rpwc_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module rpwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/relation_path_walk_count_top.sv =====
// ----------------------------------------------------------------------------
// relation_path_walk_count_top
// Edge store per (head, relation) list and a counted multi-hop path walk.
//
//   Channel  Dir  Handshake        Word
//   req      in   valid/ready      action, head, relation, tail, index
//   rsp      out  valid/ready      status, level size, entity, path count
//   cfg      in   cfg_write        entity_count (0), relation_count (1)
//
// After reset, and after every clear, a pass writes the empty marker into all
// MAX_ENTITIES*MAX_RELATIONS list heads, one per cycle; no word is taken then.
// An add reads the list tail, links the new edge and ends its chain; a step walks
// each level entry, follows its edges and then copies the new level's counts.
// The word is latched on accept; a finished result waits in the output
// register while the next word can be taken. Reset is synchronous.
// ----------------------------------------------------------------------------
module relation_path_walk_count_top #(
  parameter int MAX_ENTITIES  = 1024,
  parameter int MAX_RELATIONS = 64,
  parameter int MAX_EDGES     = 8192
) (
  input  logic                        clk,
  input  logic                        rst,
  rpwc_req_if.sink                    req,
  rpwc_rsp_if.source                  rsp,
  input  logic                        cfg_write,
  input  logic [rpwc_pkg::CFGI_W-1:0] cfg_index,
  input  logic [rpwc_pkg::CFG_W-1:0]  cfg_data
);
  import rpwc_pkg::*;

  localparam int LISTS = MAX_ENTITIES * MAX_RELATIONS;
  localparam int LCW   = $clog2(LISTS);
  localparam int EW    = $clog2(MAX_EDGES);
  localparam int EPW   = EW + 1;
  localparam int XW    = $clog2(MAX_ENTITIES);
  localparam int LAW   = $clog2(2 * MAX_ENTITIES);
  localparam int LW    = ENT_W + CNT_W;
  localparam int AW    = CNT_W + 1;
  localparam logic [EPW-1:0] EMPTY = EPW'(MAX_EDGES);

  state_t state, state_next;

  logic [ECNT_W-1:0] ent_cnt;
  logic [RCNT_W-1:0] rel_cnt;
  logic [ENT_W-1:0]  h, t, k;
  logic [REL_W-1:0]  r;
  logic [IDX_W-1:0]  idx;
  logic [EPW-1:0]    edges_used, enx;
  logic [SIZE_W-1:0] size, i, n;
  logic              half;
  logic [CNT_W-1:0]  cp;
  logic [LCW-1:0]    sweep;
  logic              sweep_rsp;
  logic [STAT_W-1:0] res_status;
  logic [ENT_W-1:0]  res_ent;
  logic [CNT_W-1:0]  res_cnt;
  logic              out_valid;

  // memory ports
  logic             fst_we, lst_we, tgt_we, nxt_we, lvl_we, acc_we;
  logic [LCW-1:0]   fst_addr, lst_addr;
  logic [EW-1:0]    tgt_addr, nxt_addr;
  logic [LAW-1:0]   lvl_addr;
  logic [XW-1:0]    acc_addr;
  logic [EPW-1:0]   fst_wdata, fst_rdata, nxt_wdata, nxt_rdata;
  logic [EW-1:0]    lst_wdata, lst_rdata;
  logic [ENT_W-1:0] tgt_rdata;
  logic [LW-1:0]    lvl_wdata, lvl_rdata;
  logic [AW-1:0]    acc_wdata, acc_rdata;

  logic accept, head_ok, tail_ok, rel_ok, full, idx_ok, out_load;
  logic fst_empty;
  logic [LCW-1:0]   add_list, step_list;
  logic [ENT_W-1:0] lvl_ent;
  logic [CNT_W:0]   acc_sum;
  logic [CNT_W-1:0] acc_new;

  rpwc_ram #(.WIDTH(EPW), .DEPTH(LISTS)) u_first (
    .clk, .we(fst_we), .addr(fst_addr), .wdata(fst_wdata), .rdata(fst_rdata));
  rpwc_ram #(.WIDTH(EW), .DEPTH(LISTS)) u_last (
    .clk, .we(lst_we), .addr(lst_addr), .wdata(lst_wdata), .rdata(lst_rdata));
  rpwc_ram #(.WIDTH(ENT_W), .DEPTH(MAX_EDGES)) u_target (
    .clk, .we(tgt_we), .addr(tgt_addr), .wdata(t), .rdata(tgt_rdata));
  rpwc_ram #(.WIDTH(EPW), .DEPTH(MAX_EDGES)) u_next (
    .clk, .we(nxt_we), .addr(nxt_addr), .wdata(nxt_wdata), .rdata(nxt_rdata));
  rpwc_ram #(.WIDTH(LW), .DEPTH(2 * MAX_ENTITIES)) u_level (
    .clk, .we(lvl_we), .addr(lvl_addr), .wdata(lvl_wdata), .rdata(lvl_rdata));
  rpwc_ram #(.WIDTH(AW), .DEPTH(MAX_ENTITIES)) u_acc (
    .clk, .we(acc_we), .addr(acc_addr), .wdata(acc_wdata), .rdata(acc_rdata));

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_load  = (state == S_DONE) && (!out_valid || rsp.ready);

  assign head_ok = (req.head_entity < ent_cnt) && (32'(req.head_entity) < MAX_ENTITIES);
  assign tail_ok = (req.tail_entity < ent_cnt) && (32'(req.tail_entity) < MAX_ENTITIES);
  assign rel_ok  = (req.relation_id < rel_cnt) && (32'(req.relation_id) < MAX_RELATIONS);
  assign full    = (edges_used == EMPTY);
  assign idx_ok  = ({1'b0, req.result_index} < size);

  assign add_list  = LCW'(LCW'(h) * LCW'(MAX_RELATIONS)) + LCW'(r);
  assign lvl_ent   = lvl_rdata[LW-1:CNT_W];
  assign step_list = LCW'(LCW'(lvl_ent) * LCW'(MAX_RELATIONS)) + LCW'(r);
  assign fst_empty = (32'(fst_rdata) >= MAX_EDGES);
  assign acc_sum   = {1'b0, acc_rdata[CNT_W-1:0]} + {1'b0, cp};
  // A first visit in this step starts the entity's sum afresh.
  assign acc_new   = !acc_rdata[CNT_W] ? cp :
                     (acc_sum[CNT_W] ? COUNT_CAP : acc_sum[CNT_W-1:0]);

  always_comb begin
    state_next = state;
    case (state)
      S_SWEEP:    if (sweep == LCW'(LISTS - 1)) state_next = sweep_rsp ? S_DONE : S_IDLE;
      S_IDLE: begin
        if (accept) begin
          case (req.action)
            ACT_CLEAR: state_next = S_SWEEP;
            ACT_ADD:   state_next = (head_ok && tail_ok && rel_ok && !full) ?
                                    S_ADD_RD : S_DONE;
            ACT_START: state_next = head_ok ? S_START : S_DONE;
            ACT_STEP:  state_next = rel_ok ? S_STEP_LV : S_DONE;
            ACT_READ:  state_next = idx_ok ? S_READ_RD : S_DONE;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_ADD_RD:   state_next = S_ADD_LINK;
      S_ADD_LINK: state_next = S_ADD_TERM;
      S_ADD_TERM: state_next = S_DONE;
      S_START:    state_next = S_DONE;
      S_READ_RD:  state_next = S_READ_D;
      S_READ_D:   state_next = S_DONE;
      S_STEP_LV:  state_next = (i < size) ? S_STEP_LVD : S_CP_RD;
      S_STEP_LVD: state_next = S_STEP_FD;
      S_STEP_FD:  state_next = fst_empty ? S_STEP_LV : S_STEP_TD;
      S_STEP_TD:  state_next = S_STEP_AD;
      S_STEP_AD:  state_next = (32'(enx) >= MAX_EDGES) ? S_STEP_LV : S_STEP_TD;
      S_CP_RD:    state_next = (i < n) ? S_CP_LD : S_DONE;
      S_CP_LD:    state_next = S_CP_AD;
      S_CP_AD:    state_next = S_CP_RD;
      S_DONE:     if (out_load) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    fst_we    = 1'b0;
    lst_we    = 1'b0;
    tgt_we    = 1'b0;
    nxt_we    = 1'b0;
    lvl_we    = 1'b0;
    acc_we    = 1'b0;
    fst_addr  = add_list;
    lst_addr  = add_list;
    fst_wdata = EPW'(edges_used[EW-1:0]);
    lst_wdata = edges_used[EW-1:0];
    tgt_addr  = edges_used[EW-1:0];
    nxt_addr  = edges_used[EW-1:0];
    nxt_wdata = edges_used;
    lvl_addr  = {half, XW'(i)};
    lvl_wdata = {k, acc_rdata[CNT_W-1:0]};
    acc_addr  = XW'(k);
    acc_wdata = {1'b1, acc_new};
    case (state)
      S_SWEEP: begin
        fst_we    = 1'b1;
        fst_addr  = sweep;
        fst_wdata = EMPTY;
        acc_we    = (32'(sweep) < MAX_ENTITIES);
        acc_addr  = XW'(sweep);
        acc_wdata = '0;
      end
      S_ADD_LINK: begin
        tgt_we = 1'b1;
        lst_we = 1'b1;
        if (fst_empty) begin
          fst_we = 1'b1;
        end else begin
          nxt_we   = 1'b1;
          nxt_addr = lst_rdata;
        end
      end
      S_ADD_TERM: begin
        nxt_we    = 1'b1;
        nxt_wdata = EMPTY;
      end
      S_START: begin
        lvl_we    = 1'b1;
        lvl_addr  = '0;
        lvl_wdata = {h, CNT_W'(1)};
      end
      S_READ_RD:  lvl_addr = {half, XW'(idx)};
      S_STEP_LVD: fst_addr = step_list;
      S_STEP_FD: begin
        tgt_addr = fst_rdata[EW-1:0];
        nxt_addr = fst_rdata[EW-1:0];
      end
      S_STEP_TD:  acc_addr = XW'(tgt_rdata);
      S_STEP_AD: begin
        acc_we    = 1'b1;
        tgt_addr  = enx[EW-1:0];
        nxt_addr  = enx[EW-1:0];
        lvl_we    = !acc_rdata[CNT_W];
        lvl_addr  = {~half, XW'(n)};
        lvl_wdata = {k, CNT_W'(0)};
      end
      S_CP_RD:    lvl_addr = {~half, XW'(i)};
      S_CP_LD:    acc_addr = XW'(lvl_ent);
      S_CP_AD: begin
        lvl_we    = 1'b1;
        lvl_addr  = {~half, XW'(i)};
        acc_we    = 1'b1;
        acc_wdata = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep      <= '0;
      sweep_rsp  <= 1'b0;
      ent_cnt    <= ENTITY_COUNT_RESET;
      rel_cnt    <= RELATION_COUNT_RESET;
      edges_used <= '0;
      size       <= '0;
      half       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        if (cfg_index == REG_ENTITY_COUNT) ent_cnt <= cfg_data;
        if (cfg_index == REG_RELATION_COUNT) rel_cnt <= cfg_data[RCNT_W-1:0];
      end
      if (rsp.ready) out_valid <= 1'b0;
      if (out_load) begin
        out_valid         <= 1'b1;
        rsp.status        <= res_status;
        rsp.level_size    <= size;
        rsp.result_entity <= res_ent;
        rsp.path_count    <= res_cnt;
      end
      case (state)
        S_SWEEP: sweep <= sweep + 1'b1;
        S_IDLE: begin
          if (accept) begin
            h          <= req.head_entity;
            r          <= req.relation_id;
            t          <= req.tail_entity;
            idx        <= req.result_index;
            res_status <= ST_OK;
            res_ent    <= '0;
            res_cnt    <= '0;
            i          <= '0;
            n          <= '0;
            case (req.action)
              ACT_CLEAR: begin
                sweep      <= '0;
                sweep_rsp  <= 1'b1;
                edges_used <= '0;
                size       <= '0;
              end
              ACT_ADD:
                if (!(head_ok && tail_ok && rel_ok)) res_status <= ST_BAD_ARG;
                else if (full)                       res_status <= ST_FULL;
              ACT_START: if (!head_ok) res_status <= ST_BAD_ARG;
              ACT_STEP:  if (!rel_ok) res_status <= ST_BAD_ARG;
              ACT_READ:  if (!idx_ok) res_status <= ST_BAD_INDEX;
              default: ;
            endcase
          end
        end
        S_ADD_TERM: edges_used <= edges_used + 1'b1;
        S_START: begin
          half <= 1'b0;
          size <= SIZE_W'(1);
        end
        S_READ_D: begin
          res_ent <= lvl_ent;
          res_cnt <= lvl_rdata[CNT_W-1:0];
        end
        S_STEP_LV: if (i >= size) i <= '0;
        S_STEP_LVD: cp <= lvl_rdata[CNT_W-1:0];
        S_STEP_FD: if (fst_empty) i <= i + 1'b1;
        S_STEP_TD: begin
          k   <= tgt_rdata;
          enx <= nxt_rdata;
        end
        S_STEP_AD: begin
          if (!acc_rdata[CNT_W]) n <= n + 1'b1;
          if (32'(enx) >= MAX_EDGES) i <= i + 1'b1;
        end
        S_CP_RD: begin
          if (i >= n) begin
            half <= ~half;
            size <= n;
          end
        end
        S_CP_LD: k <= lvl_ent;
        S_CP_AD: i <= i + 1'b1;
        default: ;
      endcase
    end
  end

  assign rsp.valid = out_valid;
endmodule

// ===== hdl/rpwc_checker.sv =====
// ----------------------------------------------------------------------------
// rpwc_checker
// Port-level checks on the relation path walk block, bound to its top level.
// ----------------------------------------------------------------------------
module rpwc_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  status,
  input logic [10:0] level_size,
  input logic [9:0]  result_entity,
  input logic [47:0] path_count
);
  // A stalled result word holds its contents.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(path_count) && $stable(status))
    else $error("result word changed while stalled");

  // The clearing pass after reset takes no word and gives no result.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !req_ready && !rsp_valid)
    else $error("activity right after reset");

  // A failed word carries no entity and no count.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != 2'd0 |-> result_entity == 10'd0 && path_count == 48'd0)
    else $error("failed word carries data");

  // A level never holds more distinct entities than ids exist.
  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> level_size <= 11'd1024)
    else $error("level size out of range");
endmodule

bind relation_path_walk_count_top rpwc_checker u_rpwc_checker (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .status(rsp.status),
  .level_size(rsp.level_size), .result_entity(rsp.result_entity),
  .path_count(rsp.path_count));
